### rtl/rfct_pkg.sv
// Package with shared constants, types and codes of the RF remote code table.
`timescale 1ns / 1ps
package rfct_pkg;
    localparam int SLOTS_DEF   = 64;
    localparam int MODELS_DEF  = 4;
    localparam int BUTTONS_DEF = 8;

    localparam logic [2:0] ACT_LOOKUP = 3'd0;
    localparam logic [2:0] ACT_ENROLL = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_FREE   = 3'd3;
    localparam logic [2:0] ACT_CHECK  = 3'd4;
    localparam logic [2:0] ACT_WOFS   = 3'd5;
    localparam logic [2:0] ACT_WHDR   = 3'd6;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_RANGE    = 2'd1;
    localparam logic [1:0] ERR_NOTFOUND = 2'd2;
    localparam logic [1:0] ERR_FULL     = 2'd3;

    typedef struct packed {
        logic start;
        logic scan_clr;
        logic slot_adv;
        logic btn_adv;
        logic rd_slot;
        logic rd_ofs;
        logic hit_ld;
        logic done;
    } rfct_cmd_t;

    typedef struct packed {
        logic       scan_last;
        logic       slot_live;
        logic       btn_last;
        logic       btn_none;
        logic       hit;
        logic [2:0] action;
    } rfct_sts_t;
endpackage

### rtl/rfct_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module rfct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

### rtl/rfct_ctrl.sv
// Controller state machine sequencing requests and the lookup scan.
`timescale 1ns / 1ps
module rfct_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output rfct_pkg::rfct_cmd_t cmd,
    input  rfct_pkg::rfct_sts_t sts
);
    import rfct_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SLOT  = 3'd1;
    localparam logic [2:0] ST_SWAIT = 3'd2;
    localparam logic [2:0] ST_BTN   = 3'd3;
    localparam logic [2:0] ST_CMP   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0] state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    if (sts.action == ACT_LOOKUP) begin
                        cmd.scan_clr = 1'b1;
                        state_next = ST_SLOT;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_SLOT: begin
                cmd.rd_slot = 1'b1;
                state_next = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (!sts.slot_live || sts.btn_none) begin
                    if (sts.scan_last) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.slot_adv = 1'b1;
                        state_next = ST_SLOT;
                    end
                end else begin
                    state_next = ST_BTN;
                end
            end
            ST_BTN: begin
                cmd.rd_ofs = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                if (sts.hit) begin
                    cmd.hit_ld = 1'b1;
                    state_next = ST_OUT;
                end else if (!sts.btn_last) begin
                    cmd.btn_adv = 1'b1;
                    state_next = ST_BTN;
                end else if (sts.scan_last) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.slot_adv = 1'b1;
                    state_next = ST_SLOT;
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    cmd.done = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

### rtl/rfct_dp.sv
// Datapath holding slot and model stores, scan counters and result register.
`timescale 1ns / 1ps
module rfct_dp #(
    parameter int SLOTS   = rfct_pkg::SLOTS_DEF,
    parameter int MODELS  = rfct_pkg::MODELS_DEF,
    parameter int BUTTONS = rfct_pkg::BUTTONS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [2:0]        s_action,
    input  logic [31:0]       s_code,
    input  logic [6:0]        s_slot_number,
    input  logic [7:0]        s_status_in,
    input  logic [1:0]        s_model_index,
    input  logic [2:0]        s_button_index,
    input  logic [31:0]       s_button_offset,
    input  logic [4:0]        s_clear_bits,
    input  logic [3:0]        s_button_count,
    output logic              m_found,
    output logic [6:0]        m_match_slot,
    output logic [7:0]        m_match_status,
    output logic [1:0]        m_match_model,
    output logic [2:0]        m_match_button,
    output logic [1:0]        m_error,
    input  rfct_pkg::rfct_cmd_t cmd,
    output rfct_pkg::rfct_sts_t sts
);
    import rfct_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW = (MODELS > 1) ? $clog2(MODELS) : 1;
    localparam int BW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CW = $clog2(BUTTONS + 1);
    localparam int RW = 2 + 8 + 32;

    logic [SLOTS-1:0]   valid_reg;
    logic [CW-1:0]      mbtn_reg [MODELS];
    logic [4:0]         mclr_reg [MODELS];
    logic [2:0]         act_reg;
    logic [31:0]        code_reg;
    logic [SW-1:0]      scan_reg;
    logic [BW-1:0]      btn_reg;
    logic               found_reg;
    logic [6:0]         slot_reg;
    logic [7:0]         status_reg;
    logic [1:0]         model_reg;
    logic [2:0]         button_reg;
    logic [1:0]         error_reg;
    logic               live_reg;

    logic               in_slot, in_model, in_btn;
    logic [SW-1:0]      sidx;
    logic [MW-1:0]      midx;
    logic               enroll_we, ofs_we;
    logic [31:0]        mask;
    logic [RW-1:0]      slot_wdata, slot_rdata;
    logic [1:0]         rd_model;
    logic [7:0]         rd_status;
    logic [31:0]        rd_base, ofs_rdata;
    logic [MW-1:0]      rd_midx;
    logic [CW-1:0]      rd_nb;
    logic [MW+BW-1:0]   ofs_waddr, ofs_raddr;
    logic               free_any;
    logic [SW-1:0]      free_idx;

    assign in_slot  = (s_slot_number >= 7'd1) && ({25'd0, s_slot_number} <= 32'(SLOTS));
    assign in_model = ({30'd0, s_model_index} < 32'(MODELS));
    assign in_btn   = ({29'd0, s_button_index} < 32'(BUTTONS));
    assign sidx     = SW'(s_slot_number - 7'd1);
    assign midx     = MW'(s_model_index);
    assign mask     = (32'd1 << mclr_reg[midx]) - 32'd1;

    assign enroll_we  = cmd.start && s_action == ACT_ENROLL && in_slot && in_model;
    assign ofs_we     = cmd.start && s_action == ACT_WOFS && in_model && in_btn;
    assign slot_wdata = {s_model_index, s_status_in, s_code & ~mask};
    assign ofs_waddr  = {midx, BW'(s_button_index)};

    rfct_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_slot_ram (
        .aclk(aclk), .we(enroll_we), .waddr(sidx), .wdata(slot_wdata),
        .raddr(scan_reg), .rdata(slot_rdata)
    );

    assign rd_model  = slot_rdata[RW-1 -: 2];
    assign rd_status = slot_rdata[39:32];
    assign rd_base   = slot_rdata[31:0];
    assign rd_midx   = MW'(rd_model);
    assign rd_nb     = mbtn_reg[rd_midx];
    assign ofs_raddr = {rd_midx, btn_reg};

    rfct_ram #(.WIDTH(32), .DEPTH(MODELS * BUTTONS)) u_ofs_ram (
        .aclk(aclk), .we(ofs_we), .waddr(ofs_waddr), .wdata(s_button_offset),
        .raddr(ofs_raddr), .rdata(ofs_rdata)
    );

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign sts.scan_last = (32'(scan_reg) == 32'(SLOTS - 1));
    assign sts.slot_live = live_reg && ({30'd0, rd_model} < 32'(MODELS));
    assign sts.btn_none  = (rd_nb == '0);
    assign sts.btn_last  = (32'(btn_reg) + 32'd1 >= 32'(rd_nb));
    assign sts.hit       = (rd_base + ofs_rdata == code_reg);
    assign sts.action    = s_action;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int m = 0; m < MODELS; m++) begin
                mbtn_reg[m] <= '0;
                mclr_reg[m] <= '0;
            end
        end else if (cmd.start) begin
            if (enroll_we) begin
                valid_reg[sidx] <= 1'b1;
            end
            if (s_action == ACT_REMOVE && in_slot) begin
                valid_reg[sidx] <= 1'b0;
            end
            if (s_action == ACT_WHDR && in_model) begin
                mclr_reg[midx] <= s_clear_bits;
                mbtn_reg[midx] <= ({28'd0, s_button_count} > 32'(BUTTONS)) ?
                                  CW'(BUTTONS) : CW'(s_button_count);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_slot) begin
            live_reg <= valid_reg[scan_reg];
        end
        if (cmd.scan_clr) begin
            scan_reg <= '0;
            btn_reg  <= '0;
        end else if (cmd.slot_adv) begin
            scan_reg <= scan_reg + SW'(1);
            btn_reg  <= '0;
        end else if (cmd.btn_adv) begin
            btn_reg <= btn_reg + BW'(1);
        end
        if (cmd.start) begin
            act_reg    <= s_action;
            code_reg   <= s_code;
            found_reg  <= 1'b0;
            slot_reg   <= '0;
            status_reg <= '0;
            model_reg  <= '0;
            button_reg <= '0;
            error_reg  <= ERR_OK;
            unique case (s_action)
                ACT_ENROLL: begin
                    if (!in_slot) error_reg <= ERR_RANGE;
                    else if (!in_model) error_reg <= ERR_NOTFOUND;
                end
                ACT_REMOVE: begin
                    if (!in_slot) error_reg <= ERR_RANGE;
                    else if (!valid_reg[sidx]) error_reg <= ERR_NOTFOUND;
                end
                ACT_FREE: begin
                    if (free_any) slot_reg <= 7'(free_idx) + 7'd1;
                    else error_reg <= ERR_FULL;
                end
                ACT_CHECK: begin
                    if (!in_slot) error_reg <= ERR_RANGE;
                    else found_reg <= valid_reg[sidx];
                end
                ACT_WOFS: begin
                    if (!(in_model && in_btn)) error_reg <= ERR_RANGE;
                end
                ACT_WHDR: begin
                    if (!in_model) error_reg <= ERR_RANGE;
                end
                default: ;
            endcase
        end else if (cmd.hit_ld) begin
            found_reg  <= 1'b1;
            slot_reg   <= 7'(32'(scan_reg) + 32'd1);
            status_reg <= rd_status;
            model_reg  <= rd_model;
            button_reg <= 3'(btn_reg);
        end
    end

    assign m_found        = found_reg;
    assign m_match_slot   = slot_reg;
    assign m_match_status = status_reg;
    assign m_match_model  = model_reg;
    assign m_match_button = button_reg;
    assign m_error        = (act_reg == ACT_LOOKUP) ? ERR_OK : error_reg;
endmodule

### rtl/rf_remote_code_table_unit.sv
// Top level of the RF remote code table: controller plus datapath.
// A non-lookup result is valid the cycle after acceptance; a new request is taken only once the last is accepted.
// Lookup walks the slots in order, reading each slot and then each button offset of a live
// slot in turn until a hit or the last slot; one request at a time.
// The scan rate is set by the registered reads of the slot and offset RAMs.
// Synchronous active-low reset empties all slots and clears model headers.
`timescale 1ns / 1ps
module rf_remote_code_table_unit #(
    parameter int SLOTS   = rfct_pkg::SLOTS_DEF,
    parameter int MODELS  = rfct_pkg::MODELS_DEF,
    parameter int BUTTONS = rfct_pkg::BUTTONS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_action,
    input  logic [31:0] s_code,
    input  logic [6:0]  s_slot_number,
    input  logic [7:0]  s_status_in,
    input  logic [1:0]  s_model_index,
    input  logic [2:0]  s_button_index,
    input  logic [31:0] s_button_offset,
    input  logic [4:0]  s_clear_bits,
    input  logic [3:0]  s_button_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [6:0]  m_match_slot,
    output logic [7:0]  m_match_status,
    output logic [1:0]  m_match_model,
    output logic [2:0]  m_match_button,
    output logic [1:0]  m_error
);
    import rfct_pkg::*;

    rfct_cmd_t cmd;
    rfct_sts_t sts;

    rfct_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    rfct_dp #(.SLOTS(SLOTS), .MODELS(MODELS), .BUTTONS(BUTTONS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_action(s_action), .s_code(s_code), .s_slot_number(s_slot_number),
        .s_status_in(s_status_in), .s_model_index(s_model_index),
        .s_button_index(s_button_index), .s_button_offset(s_button_offset),
        .s_clear_bits(s_clear_bits), .s_button_count(s_button_count),
        .m_found(m_found), .m_match_slot(m_match_slot),
        .m_match_status(m_match_status), .m_match_model(m_match_model),
        .m_match_button(m_match_button), .m_error(m_error),
        .cmd(cmd), .sts(sts)
    );
endmodule
